[rtl/ads_pkg.sv]
`default_nettype none

package ads_pkg;

    // Width of the signed day offset that is taken from the input port.
    localparam int OFFSET_BITS = 24;

    // Signed width of the shifted serial day sum: holds the largest date serial plus any offset.
    localparam int Z_BITS = ((OFFSET_BITS > 22) ? OFFSET_BITS : 22) + 2;

    // Register stages from the start strobe to the result strobe.
    localparam int PIPE_DEPTH = 15;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DASH = 8'h2D;

    localparam logic [13:0] YEAR_MIN = 14'd1970;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // Days in one 400 year cycle.
    localparam int ERA_DAYS = 146097;

    // The serial is counted from March 1 of year -400, so every legal result is positive.
    // 0000-01-01 sits 60 days before the first March 1 of year 0.
    localparam int T_MIN = ERA_DAYS - 60;
    // 9999-12-31.
    localparam int T_MAX = 3798461;

    // Round-up reciprocals: floor(x / D) == (x * M) >> S for every x below 2**n,
    // where S = n + ceil(log2(D)).
    localparam int          SH_C100  = 21;  // x < 2**14
    localparam logic [63:0] M_C100   = ((64'd1 << SH_C100) + 64'd99) / 64'd100;
    localparam int          SH_ERA   = 40;  // x < 2**22
    localparam logic [63:0] M_ERA    = ((64'd1 << SH_ERA) + 64'd146096) / 64'd146097;
    localparam int          SH_C1460 = 29;  // x < 2**18
    localparam logic [63:0] M_C1460  = ((64'd1 << SH_C1460) + 64'd1459) / 64'd1460;
    localparam int          SH_C36524 = 34; // x < 2**18
    localparam logic [63:0] M_C36524 = ((64'd1 << SH_C36524) + 64'd36523) / 64'd36524;
    localparam int          SH_C365  = 27;  // x < 2**18
    localparam logic [63:0] M_C365   = ((64'd1 << SH_C365) + 64'd364) / 64'd365;
    localparam int          SH_C100S = 16;  // x < 2**9
    localparam logic [63:0] M_C100S  = ((64'd1 << SH_C100S) + 64'd99) / 64'd100;
    localparam int          SH_C153  = 19;  // x < 2**11
    localparam logic [63:0] M_C153   = ((64'd1 << SH_C153) + 64'd152) / 64'd153;
    localparam int          SH_C10   = 11;  // x < 2**7
    localparam logic [63:0] M_C10    = ((64'd1 << SH_C10) + 64'd9) / 64'd10;

    // Days in a calendar month, zero for a month code that means nothing.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first day of the month, months counted from March.
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] days;
        unique case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Day of a March-based year at which a calendar month starts.
    function automatic logic [8:0] doy_base(input logic [3:0] mon);
        logic [3:0] mp;
        mp = (mon > 4'd2) ? mon - 4'd3 : mon + 4'd9;
        return cum_days(mp);
    endfunction

    // Two ASCII digits of a value below 100, tens in the upper byte.
    function automatic logic [15:0] two_digits(input logic [6:0] val);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(val) * 15'(M_C10);
        tens  = 4'(prod >> SH_C10);
        units = val - 7'(tens) * 7'd10;
        return {CH_ZERO + 8'(tens), CH_ZERO + 8'(units)};
    endfunction

endpackage

`default_nettype wire

[rtl/ascii_date_day_shifter.sv]
// Adds a signed day offset to an ASCII date "YYYY-MM-DD" and returns the
// shifted date in ASCII with o_ok. A date is taken on every cycle with start
// high; busy is always low, so one date per clock is sustained. Each result
// appears on o_valid exactly 15 cycles after its start, in order, for one
// cycle only: the receiver cannot hold it off and must take it then. The
// latency is set by the 15 register stages of the constant-reciprocal
// multipliers that convert the date to a day serial and back. A malformed
// date, a year before 1970, a bad month or day, or a result outside years
// 0..9999 gives o_ok low and all characters zero.

`default_nettype none

module ascii_date_day_shifter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [7:0]                            i_in_char_0,
    input  logic [7:0]                            i_in_char_1,
    input  logic [7:0]                            i_in_char_2,
    input  logic [7:0]                            i_in_char_3,
    input  logic [7:0]                            i_in_char_4,
    input  logic [7:0]                            i_in_char_5,
    input  logic [7:0]                            i_in_char_6,
    input  logic [7:0]                            i_in_char_7,
    input  logic [7:0]                            i_in_char_8,
    input  logic [7:0]                            i_in_char_9,
    input  logic signed [ads_pkg::OFFSET_BITS-1:0] i_day_offset,
    output logic                                  o_valid,
    output logic [7:0]                            o_out_char_0,
    output logic [7:0]                            o_out_char_1,
    output logic [7:0]                            o_out_char_2,
    output logic [7:0]                            o_out_char_3,
    output logic [7:0]                            o_out_char_4,
    output logic [7:0]                            o_out_char_5,
    output logic [7:0]                            o_out_char_6,
    output logic [7:0]                            o_out_char_7,
    output logic [7:0]                            o_out_char_8,
    output logic [7:0]                            o_out_char_9,
    output logic                                  o_ok
);

    localparam int ZB = ads_pkg::Z_BITS;

    // Control: valid and ok travel with each transaction.
    logic [ads_pkg::PIPE_DEPTH-1:0] r_vld;
    logic [ads_pkg::PIPE_DEPTH-1:0] r_ok;
    logic [ads_pkg::PIPE_DEPTH-1:0] n_ok;

    // Stage A: parse and check.
    logic [7:0]  ch [10];
    logic [3:0]  dv [10];
    logic        fmt_ok;
    logic        leap;
    logic        date_ok;
    logic [13:0] yr;
    logic [6:0]  yr_hi;
    logic [6:0]  yr_lo;
    logic [6:0]  mo;
    logic [6:0]  dy;
    logic [4:0]  maxd;
    logic [13:0] n_a_yp;
    logic [8:0]  n_a_doy;
    logic [13:0] r_a_yp;
    logic [8:0]  r_a_doy;
    logic signed [ads_pkg::OFFSET_BITS-1:0] r_a_off;

    // Stage B: days up to the input date, and its year divided by 100.
    logic [28:0] prod_b;
    logic [6:0]  n_b_q100;
    logic [21:0] n_b_p;
    logic [6:0]  r_b_q100;
    logic [21:0] r_b_p;
    logic signed [ads_pkg::OFFSET_BITS-1:0] r_b_off;

    // Stage C: add offset and check range.
    logic signed [ZB-1:0] t_full;
    logic        in_range;
    logic [21:0] r_c_t;

    // Stage D: era.
    logic [44:0] prod_d;
    logic [4:0]  n_d_era;
    logic [4:0]  r_d_era;
    logic [21:0] r_d_t;

    // Stage E: day of era.
    logic [17:0] n_e_doe;
    logic [17:0] r_e_doe;
    logic [4:0]  r_e_era;

    // Stage F: leap corrections.
    logic [36:0] prod_f1;
    logic [36:0] prod_f2;
    logic [6:0]  r_f_a1;
    logic [2:0]  r_f_a2;
    logic [17:0] r_f_doe;
    logic [4:0]  r_f_era;

    // Stage G.
    logic [17:0] r_g_n;
    logic [17:0] r_g_doe;
    logic [4:0]  r_g_era;

    // Stage H: year of era.
    logic [36:0] prod_h;
    logic [8:0]  r_h_yoe;
    logic [17:0] r_h_doe;
    logic [4:0]  r_h_era;

    // Stage I.
    logic [18:0] prod_i;
    logic [1:0]  r_i_yc;
    logic [8:0]  r_i_yoe;
    logic [17:0] r_i_doe;
    logic [4:0]  r_i_era;

    // Stage J: day of year, shifted year.
    logic [8:0]  r_j_doy;
    logic [13:0] r_j_yr;

    // Stage K: March-based month.
    logic [11:0] k_x;
    logic [23:0] prod_k;
    logic [3:0]  r_k_mp;
    logic [8:0]  r_k_doy;
    logic [13:0] r_k_yr;

    // Stage L: calendar month, day, year.
    logic [3:0]  n_l_mon;
    logic [3:0]  r_l_mon;
    logic [4:0]  r_l_dd;
    logic [13:0] r_l_ry;

    // Stage M and N: year into two halves.
    logic [28:0] prod_m;
    logic [6:0]  r_m_h;
    logic [13:0] r_m_ry;
    logic [3:0]  r_m_mon;
    logic [4:0]  r_m_dd;
    logic [6:0]  r_n_h;
    logic [6:0]  r_n_lo;
    logic [3:0]  r_n_mon;
    logic [4:0]  r_n_dd;

    // Stage O: characters.
    logic [15:0] pr_h;
    logic [15:0] pr_lo;
    logic [15:0] pr_mon;
    logic [15:0] pr_dd;
    logic [7:0]  n_o_char [10];
    logic [7:0]  r_o_char [10];

    assign busy = 1'b0;

    assign ch[0] = i_in_char_0;
    assign ch[1] = i_in_char_1;
    assign ch[2] = i_in_char_2;
    assign ch[3] = i_in_char_3;
    assign ch[4] = i_in_char_4;
    assign ch[5] = i_in_char_5;
    assign ch[6] = i_in_char_6;
    assign ch[7] = i_in_char_7;
    assign ch[8] = i_in_char_8;
    assign ch[9] = i_in_char_9;

    always_comb begin
        fmt_ok = (ch[4] == ads_pkg::CH_DASH) && (ch[7] == ads_pkg::CH_DASH);
        for (int k = 0; k < 10; k++) begin
            dv[k] = 4'(ch[k] - ads_pkg::CH_ZERO);
            if (k != 4 && k != 7 &&
                (ch[k] < ads_pkg::CH_ZERO || ch[k] > ads_pkg::CH_NINE)) begin
                fmt_ok = 1'b0;
            end
        end
        yr    = 14'(dv[0]) * 14'd1000 + 14'(dv[1]) * 14'd100 + 14'(dv[2]) * 14'd10
              + 14'(dv[3]);
        yr_hi = 7'(dv[0]) * 7'd10 + 7'(dv[1]);
        yr_lo = 7'(dv[2]) * 7'd10 + 7'(dv[3]);
        mo    = 7'(dv[5]) * 7'd10 + 7'(dv[6]);
        dy    = 7'(dv[8]) * 7'd10 + 7'(dv[9]);
        // Leap: divisible by 4, and a century year only when divisible by 400.
        leap  = (yr_lo[1:0] == 2'd0) && ((yr_lo != 7'd0) || (yr_hi[1:0] == 2'd0));
        maxd  = ads_pkg::month_len(mo[3:0], leap);
        date_ok = fmt_ok && (yr >= ads_pkg::YEAR_MIN) && (yr <= ads_pkg::YEAR_MAX)
               && (mo >= 7'd1) && (mo <= 7'd12) && (dy >= 7'd1) && (dy <= 7'(maxd));
        // January and February count with the year before.
        n_a_yp  = yr - 14'(mo <= 7'd2);
        n_a_doy = ads_pkg::doy_base(mo[3:0]) + 9'(dy) - 9'd1;
    end

    always_comb begin
        prod_b   = 29'(r_a_yp) * 29'(ads_pkg::M_C100);
        n_b_q100 = 7'(prod_b >> ads_pkg::SH_C100);
        n_b_p    = 22'(r_a_yp) * 22'd365 + 22'(r_a_yp >> 2) + 22'(r_a_doy);
    end

    always_comb begin
        t_full = $signed(ZB'(r_b_p)) - $signed(ZB'(r_b_q100))
               + $signed(ZB'(r_b_q100 >> 2)) + ZB'(r_b_off)
               + $signed(ZB'(ads_pkg::ERA_DAYS));
        in_range = (t_full >= $signed(ZB'(ads_pkg::T_MIN)))
                && (t_full <= $signed(ZB'(ads_pkg::T_MAX)));
    end

    always_comb begin
        prod_d  = 45'(r_c_t) * 45'(ads_pkg::M_ERA);
        n_d_era = 5'(prod_d >> ads_pkg::SH_ERA);
        n_e_doe = 18'(r_d_t - 22'(r_d_era) * 22'(ads_pkg::ERA_DAYS));
        prod_f1 = 37'(r_e_doe) * 37'(ads_pkg::M_C1460);
        prod_f2 = 37'(r_e_doe) * 37'(ads_pkg::M_C36524);
        prod_h  = 37'(r_g_n) * 37'(ads_pkg::M_C365);
        prod_i  = 19'(r_h_yoe) * 19'(ads_pkg::M_C100S);
        k_x     = 12'(r_j_doy) * 12'd5 + 12'd2;
        prod_k  = 24'(k_x) * 24'(ads_pkg::M_C153);
        n_l_mon = (r_k_mp < 4'd10) ? r_k_mp + 4'd3 : r_k_mp - 4'd9;
        prod_m  = 29'(r_l_ry) * 29'(ads_pkg::M_C100);
    end

    always_comb begin
        pr_h   = ads_pkg::two_digits(r_n_h);
        pr_lo  = ads_pkg::two_digits(r_n_lo);
        pr_mon = ads_pkg::two_digits(7'(r_n_mon));
        pr_dd  = ads_pkg::two_digits(7'(r_n_dd));
        n_o_char[0] = pr_h[15:8];
        n_o_char[1] = pr_h[7:0];
        n_o_char[2] = pr_lo[15:8];
        n_o_char[3] = pr_lo[7:0];
        n_o_char[4] = ads_pkg::CH_DASH;
        n_o_char[5] = pr_mon[15:8];
        n_o_char[6] = pr_mon[7:0];
        n_o_char[7] = ads_pkg::CH_DASH;
        n_o_char[8] = pr_dd[15:8];
        n_o_char[9] = pr_dd[7:0];
        // Drop the characters of a failed transaction.
        if (!r_ok[ads_pkg::PIPE_DEPTH-2]) begin
            for (int k = 0; k < 10; k++) begin
                n_o_char[k] = 8'h00;
            end
        end
    end

    always_comb begin
        n_ok    = {r_ok[ads_pkg::PIPE_DEPTH-2:0], date_ok};
        n_ok[2] = r_ok[1] && in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ok  <= '0;
        end else begin
            r_vld <= {r_vld[ads_pkg::PIPE_DEPTH-2:0], start};
            r_ok  <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_yp   <= n_a_yp;
        r_a_doy  <= n_a_doy;
        r_a_off  <= i_day_offset;

        r_b_q100 <= n_b_q100;
        r_b_p    <= n_b_p;
        r_b_off  <= r_a_off;

        r_c_t    <= t_full[21:0];

        r_d_era  <= n_d_era;
        r_d_t    <= r_c_t;

        r_e_doe  <= n_e_doe;
        r_e_era  <= r_d_era;

        r_f_a1   <= 7'(prod_f1 >> ads_pkg::SH_C1460);
        r_f_a2   <= 3'(prod_f2 >> ads_pkg::SH_C36524);
        r_f_doe  <= r_e_doe;
        r_f_era  <= r_e_era;

        r_g_n    <= r_f_doe - 18'(r_f_a1) + 18'(r_f_a2) - 18'(r_f_doe == 18'd146096);
        r_g_doe  <= r_f_doe;
        r_g_era  <= r_f_era;

        r_h_yoe  <= 9'(prod_h >> ads_pkg::SH_C365);
        r_h_doe  <= r_g_doe;
        r_h_era  <= r_g_era;

        r_i_yc   <= 2'(prod_i >> ads_pkg::SH_C100S);
        r_i_yoe  <= r_h_yoe;
        r_i_doe  <= r_h_doe;
        r_i_era  <= r_h_era;

        r_j_doy  <= 9'(r_i_doe - (18'(r_i_yoe) * 18'd365 + 18'(r_i_yoe >> 2)
                    - 18'(r_i_yc)));
        r_j_yr   <= 14'(r_i_yoe) + 14'(r_i_era) * 14'd400;

        r_k_mp   <= 4'(prod_k >> ads_pkg::SH_C153);
        r_k_doy  <= r_j_doy;
        r_k_yr   <= r_j_yr;

        r_l_mon  <= n_l_mon;
        r_l_dd   <= 5'(r_k_doy - ads_pkg::cum_days(r_k_mp) + 9'd1);
        // Undo the one-era shift and move January and February into the next year.
        r_l_ry   <= r_k_yr - 14'd400 + 14'(n_l_mon <= 4'd2);

        r_m_h    <= 7'(prod_m >> ads_pkg::SH_C100);
        r_m_ry   <= r_l_ry;
        r_m_mon  <= r_l_mon;
        r_m_dd   <= r_l_dd;

        r_n_h    <= r_m_h;
        r_n_lo   <= 7'(r_m_ry - 14'(r_m_h) * 14'd100);
        r_n_mon  <= r_m_mon;
        r_n_dd   <= r_m_dd;

        r_o_char <= n_o_char;
    end

    assign o_valid      = r_vld[ads_pkg::PIPE_DEPTH-1];
    assign o_ok         = r_ok[ads_pkg::PIPE_DEPTH-1];
    assign o_out_char_0 = r_o_char[0];
    assign o_out_char_1 = r_o_char[1];
    assign o_out_char_2 = r_o_char[2];
    assign o_out_char_3 = r_o_char[3];
    assign o_out_char_4 = r_o_char[4];
    assign o_out_char_5 = r_o_char[5];
    assign o_out_char_6 = r_o_char[6];
    assign o_out_char_7 = r_o_char[7];
    assign o_out_char_8 = r_o_char[8];
    assign o_out_char_9 = r_o_char[9];

endmodule

`default_nettype wire
